@@ design/sbd_pkg.sv @@
`default_nettype none
package sbd_pkg;
  localparam int ND       = 16;
  localparam int DW       = $clog2(ND);
  localparam int MAX_W    = 1024;
  localparam int MAX_H    = 4096;
  localparam int XW       = $clog2(MAX_W);
  localparam int YW       = $clog2(MAX_H);
  localparam int PW       = XW + YW;
  localparam int WIN      = 5;
  localparam int ROWS     = WIN - 1;
  localparam int CSW      = 11;
  localparam int HSW      = 13;
  localparam int DIV_MUL  = 5243;
  localparam int DIV_SH   = 17;
  localparam int CFG_DW   = 13;
  localparam int CFG_IW   = 2;
  localparam int RST_MAXD = 13;
  localparam int RST_W    = 640;
  localparam int RST_H    = 480;

  localparam logic [CFG_IW-1:0] CFG_MAXD   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;

  typedef logic [ND-1:0][7:0]      cost_vec_t;
  typedef logic [ROWS-1:0][ND-1:0][7:0] line_t;
  typedef logic [ND-1:0][CSW-1:0]  col_vec_t;

  typedef struct packed {
    logic valid;
    logic pix;
    logic emit;
    logic fend;
    logic interior;
  } ctl_t;
endpackage
`default_nettype wire

@@ design/sbd_if.sv @@
`default_nettype none
interface sbd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;
  modport source (output valid, operation, left_pixel, right_pixel, input ready);
  modport sink (input valid, operation, left_pixel, right_pixel, output ready);
endinterface

interface sbd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] disparity;
  logic [7:0] best_cost;
  logic       frame_end;
  modport source (output valid, disparity, best_cost, frame_end, input ready);
  modport sink (input valid, disparity, best_cost, frame_end, output ready);
endinterface
`default_nettype wire

@@ design/sbd_line_store.sv @@
`default_nettype none
module sbd_line_store
  import sbd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [XW-1:0] rd_addr,
  output line_t              rd_data_r,
  input  wire logic          wr_en,
  input  wire logic [XW-1:0] wr_addr,
  input  wire line_t         wr_data
);
  line_t mem [MAX_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ design/sbd_window_filter.sv @@
`default_nettype none
module sbd_window_filter
  import sbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     adv,
  input  wire logic     shift_en,
  input  wire col_vec_t col_in,
  output cost_vec_t     filt_r
);
  col_vec_t                 cols_r [WIN];
  logic [ND-1:0][HSW-1:0]   hsum_r;
  logic [ND-1:0][HSW-1:0]   hsum_nxt;
  cost_vec_t                filt_nxt;
  logic [2*HSW-1:0]         prod;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      hsum_nxt[d] = '0;
      for (int k = 0; k < WIN; k++) begin
        hsum_nxt[d] = hsum_nxt[d] + HSW'(cols_r[k][d]);
      end
    end
  end

  always_comb begin
    prod = '0;
    for (int d = 0; d < ND; d++) begin
      prod = hsum_r[d] * HSW'(DIV_MUL);
      filt_nxt[d] = prod[DIV_SH +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      cols_r[0] <= col_in;
      for (int k = 1; k < WIN; k++) begin
        cols_r[k] <= cols_r[k-1];
      end
    end
    if (adv) begin
      hsum_r <= hsum_nxt;
      filt_r <= filt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/sbd_wta_select.sv @@
`default_nettype none
module sbd_wta_select
  import sbd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [DW-1:0] maxd,
  input  wire cost_vec_t     filt,
  output logic [DW-1:0]      best_d,
  output logic [7:0]         best_c
);
  localparam int HALF = ND / 2;

  logic [DW-1:0] lo_d_r, hi_d_r, lo_d_nxt, hi_d_nxt;
  logic [7:0]    lo_c_r, hi_c_r, lo_c_nxt, hi_c_nxt;
  logic          hi_ok_r, hi_ok_nxt;

  always_comb begin
    lo_d_nxt  = '0;
    lo_c_nxt  = filt[0];
    hi_d_nxt  = DW'(HALF);
    hi_c_nxt  = filt[HALF];
    hi_ok_nxt = (DW'(HALF) <= maxd);
    for (int d = 1; d < HALF; d++) begin
      if (DW'(d) <= maxd && filt[d] < lo_c_nxt) begin
        lo_c_nxt = filt[d];
        lo_d_nxt = DW'(d);
      end
    end
    for (int d = HALF + 1; d < ND; d++) begin
      if (DW'(d) <= maxd && filt[d] < hi_c_nxt) begin
        hi_c_nxt = filt[d];
        hi_d_nxt = DW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_d_r  <= lo_d_nxt;
      lo_c_r  <= lo_c_nxt;
      hi_d_r  <= hi_d_nxt;
      hi_c_r  <= hi_c_nxt;
      hi_ok_r <= hi_ok_nxt;
    end
  end

  always_comb begin
    if (hi_ok_r && hi_c_r < lo_c_r) begin
      best_d = hi_d_r;
      best_c = hi_c_r;
    end else begin
      best_d = lo_d_r;
      best_c = lo_c_r;
    end
  end
endmodule
`default_nettype wire

@@ design/sad_box_stereo_disparity_core.sv @@
// SAD block-matching stereo disparity with a 5x5 box window.
// in_req carries one request per pixel pair (operation 0) or a flush tick
// (operation 1); out_req returns at most one result per request.
// One request is taken per clock while out_req is not stalled. Each pixel
// request passes a six-stage pipeline: cost and line-store read, vertical
// sum and write-back, horizontal sum, divide by 25, two-level minimum
// search, output register. The line store is one 1024-entry RAM port pair
// read at column x and written back from the stage-1 registers at s1_x_r.
// The reported value lags the pixel stream by two rows plus two pixels;
// flush ticks drain the owed tail as zero-cost border results.
// When out_req.ready is low with a result held, the whole pipeline freezes
// and in_req.ready drops in the same cycle.
// Reset (rst_n low at a clock edge) restores the default registers and
// clears positions and the owed count; the stores need no initialization.
// cfg_we writes register cfg_index (0 max disparity, 1 width, 2 height);
// a geometry write restarts the frame. Write only while idle.
`default_nettype none
module sad_box_stereo_disparity_core
  import sbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  sbd_in_if.sink                 in_req,
  sbd_out_if.source              out_req,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);
  logic [DW-1:0]   maxd_r;
  logic [XW:0]     width_r;
  logic [YW:0]     height_r;
  logic [XW-1:0]   x_r;
  logic [YW-1:0]   y_r;
  logic [PW-1:0]   pos_r;
  logic [11:0]     pend_r;
  logic [7:0]      hist_r [ND-1];

  ctl_t            ctl_r [5];
  ctl_t            ctl_nxt;
  logic [XW-1:0]   s1_x_r;
  logic [1:0]      s1_slot_r;
  cost_vec_t       s1_cost_r;
  cost_vec_t       cost_nxt;

  logic            adv, in_fire, pix_fire;
  logic [11:0]     thr;
  logic            last_x, last_y;
  line_t           rd_data, wr_data;
  col_vec_t        col_sum;
  cost_vec_t       filt;
  logic [DW-1:0]   best_d;
  logic [7:0]      best_c;

  logic            out_valid_r;
  logic [3:0]      out_disp_r;
  logic [7:0]      out_cost_r;
  logic            out_fend_r;

  assign adv          = !out_valid_r || out_req.ready;
  assign in_req.ready = adv;
  assign in_fire      = in_req.valid && adv;
  assign pix_fire     = in_fire && !in_req.operation;
  assign thr          = {width_r, 1'b0} + 12'd2;
  assign last_x       = ({1'b0, x_r} == width_r - 1'b1);
  assign last_y       = ({1'b0, y_r} == height_r - 1'b1);

  always_comb begin
    cost_nxt[0] = (in_req.left_pixel > in_req.right_pixel) ?
                  in_req.left_pixel - in_req.right_pixel :
                  in_req.right_pixel - in_req.left_pixel;
    for (int d = 1; d < ND; d++) begin
      if (XW'(d) <= x_r) begin
        cost_nxt[d] = (in_req.left_pixel > hist_r[d-1]) ?
                      in_req.left_pixel - hist_r[d-1] :
                      hist_r[d-1] - in_req.left_pixel;
      end else begin
        cost_nxt[d] = '0;
      end
    end
  end

  always_comb begin
    ctl_nxt = '0;
    if (in_fire) begin
      if (!in_req.operation) begin
        ctl_nxt.valid    = 1'b1;
        ctl_nxt.pix      = 1'b1;
        ctl_nxt.emit     = (pend_r == thr);
        ctl_nxt.fend     = (pend_r == thr) && (x_r == XW'(1)) && (y_r == YW'(2));
        ctl_nxt.interior = (x_r >= XW'(ROWS)) && (y_r >= YW'(ROWS));
      end else if (pend_r != '0) begin
        ctl_nxt.valid = 1'b1;
        ctl_nxt.emit  = 1'b1;
        ctl_nxt.fend  = ({{(PW-12){1'b0}}, pend_r} == pos_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r   <= DW'(RST_MAXD);
      width_r  <= (XW+1)'(RST_W);
      height_r <= (YW+1)'(RST_H);
      x_r      <= '0;
      y_r      <= '0;
      pos_r    <= '0;
      pend_r   <= '0;
      for (int k = 0; k < 5; k++) begin
        ctl_r[k] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAXD: begin
            maxd_r <= cfg_data[DW-1:0];
          end
          CFG_WIDTH: begin
            if (cfg_data[XW:0] < (XW+1)'(WIN)) begin
              width_r <= (XW+1)'(WIN);
            end else if (cfg_data[XW:0] > (XW+1)'(MAX_W)) begin
              width_r <= (XW+1)'(MAX_W);
            end else begin
              width_r <= cfg_data[XW:0];
            end
            x_r    <= '0;
            y_r    <= '0;
            pos_r  <= '0;
            pend_r <= '0;
          end
          CFG_HEIGHT: begin
            if (cfg_data[YW:0] < (YW+1)'(WIN)) begin
              height_r <= (YW+1)'(WIN);
            end else if (cfg_data[YW:0] > (YW+1)'(MAX_H)) begin
              height_r <= (YW+1)'(MAX_H);
            end else begin
              height_r <= cfg_data[YW:0];
            end
            x_r    <= '0;
            y_r    <= '0;
            pos_r  <= '0;
            pend_r <= '0;
          end
          default: begin
          end
        endcase
      end else if (in_fire) begin
        if (!in_req.operation) begin
          if (last_x) begin
            x_r <= '0;
            if (last_y) begin
              y_r   <= '0;
              pos_r <= '0;
            end else begin
              y_r   <= y_r + 1'b1;
              pos_r <= pos_r + 1'b1;
            end
          end else begin
            x_r   <= x_r + 1'b1;
            pos_r <= pos_r + 1'b1;
          end
          if (pend_r != thr) begin
            pend_r <= pend_r + 1'b1;
          end
        end else if (pend_r != '0) begin
          pend_r <= pend_r - 1'b1;
        end
      end
      if (adv) begin
        ctl_r[0] <= ctl_nxt;
        for (int k = 1; k < 5; k++) begin
          ctl_r[k] <= ctl_r[k-1];
        end
        out_valid_r <= ctl_r[4].valid && ctl_r[4].emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      hist_r[0] <= in_req.right_pixel;
      for (int k = 1; k < ND - 1; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
    if (adv) begin
      s1_x_r    <= x_r;
      s1_slot_r <= y_r[1:0];
      s1_cost_r <= cost_nxt;
      if (ctl_r[4].interior) begin
        out_disp_r <= 4'(best_d);
        out_cost_r <= best_c;
      end else begin
        out_disp_r <= '0;
        out_cost_r <= '0;
      end
      out_fend_r <= ctl_r[4].fend;
    end
  end

  always_comb begin
    wr_data = rd_data;
    for (int d = 0; d < ND; d++) begin
      col_sum[d] = CSW'(s1_cost_r[d]);
      for (int r = 0; r < ROWS; r++) begin
        col_sum[d] = col_sum[d] + CSW'(rd_data[r][d]);
      end
      wr_data[s1_slot_r][d] = s1_cost_r[d];
    end
  end

  sbd_line_store u_line_store (
    .clk       (clk),
    .rd_en     (adv),
    .rd_addr   (x_r),
    .rd_data_r (rd_data),
    .wr_en     (adv && ctl_r[0].valid && ctl_r[0].pix),
    .wr_addr   (s1_x_r),
    .wr_data   (wr_data)
  );

  sbd_window_filter u_window_filter (
    .clk      (clk),
    .adv      (adv),
    .shift_en (adv && ctl_r[0].valid && ctl_r[0].pix),
    .col_in   (col_sum),
    .filt_r   (filt)
  );

  sbd_wta_select u_wta_select (
    .clk    (clk),
    .adv    (adv),
    .maxd   (maxd_r),
    .filt   (filt),
    .best_d (best_d),
    .best_c (best_c)
  );

  assign out_req.valid     = out_valid_r;
  assign out_req.disparity = out_disp_r;
  assign out_req.best_cost = out_cost_r;
  assign out_req.frame_end = out_fend_r;

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= thr) else $error("owed count above threshold");

  a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl_r[0].valid && ctl_r[0].pix) |-> (s1_x_r != x_r || !in_req.valid))
    else $error("line store read and write collide");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl_r[4].valid && ctl_r[4].emit && !ctl_r[4].interior) |=>
    (out_req.valid && out_req.disparity == 4'd0 && out_req.best_cost == 8'd0))
    else $error("border result not zero");
`endif
endmodule
`default_nettype wire

@@ tb/sad_box_stereo_disparity_core_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sad_box_stereo_disparity_core_test;
  import sbd_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam bit OP_PIXEL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    bit       op;
    bit [7:0] lp;
    bit [7:0] rp;
  } pix_req_t;

  typedef struct {
    bit [3:0] disparity;
    bit [7:0] best_cost;
    bit       frame_end;
  } disp_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  sbd_in_if  in_req ();
  sbd_out_if out_req ();

  initial begin
    in_req.valid = 1'b0;
    in_req.operation = 1'b0;
    in_req.left_pixel = 8'd0;
    in_req.right_pixel = 8'd0;
    out_req.ready = 1'b0;
  end

  sad_box_stereo_disparity_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_req  (out_req),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  pix_req_t  pixel_q[$];
  disp_res_t disp_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  // disparity predictor state
  int unsigned m_maxd, m_width, m_height;
  bit [7:0]  m_rhist[ND];
  bit [7:0]  m_lines[ROWS][MAX_W][ND];
  bit [15:0] m_colsum[WIN][ND];
  int unsigned m_x, m_y, m_owed;

  function automatic int unsigned eff_w();
    return m_width < WIN ? WIN : (m_width > MAX_W ? MAX_W : m_width);
  endfunction

  function automatic int unsigned eff_h();
    return m_height < WIN ? WIN : (m_height > MAX_H ? MAX_H : m_height);
  endfunction

  function automatic void owe_out(int unsigned d, int unsigned c);
    int unsigned sz, nxt, idx;
    disp_res_t r;
    sz = eff_w() * eff_h();
    nxt = m_y * eff_w() + m_x;
    idx = (nxt + sz - m_owed) % sz;
    r.disparity = d[3:0];
    r.best_cost = c[7:0];
    r.frame_end = (idx == sz - 1);
    disp_q.push_back(r);
    m_owed--;
  endfunction

  function automatic void predict_disparity(pix_req_t q);
    int unsigned w, h, x, y, c, cs, s, f, bd, bc, maxd, rr;
    w = eff_w();
    h = eff_h();
    x = m_x;
    y = m_y;
    bd = 0;
    bc = 0;
    if (q.op == OP_FLUSH) begin
      if (m_owed != 0) owe_out(0, 0);
      return;
    end
    for (int d = 0; d < ND; d++) begin
      c = 0;
      if (d == 0) begin
        c = q.lp > q.rp ? q.lp - q.rp : q.rp - q.lp;
      end else if (d <= x) begin
        rr = m_rhist[d-1];
        c = q.lp > rr ? q.lp - rr : rr - q.lp;
      end
      cs = c;
      for (int k = 0; k < ROWS; k++) cs += m_lines[k][x][d];
      m_lines[y % ROWS][x][d] = c[7:0];
      m_colsum[x % WIN][d] = cs[15:0];
    end
    for (int k = ND - 1; k > 0; k--) m_rhist[k] = m_rhist[k-1];
    m_rhist[0] = q.rp;
    if (x >= WIN - 1 && y >= WIN - 1) begin
      maxd = m_maxd > ND - 1 ? ND - 1 : m_maxd;
      bc = 32'hFFFF_FFFF;
      for (int d = 0; d <= maxd; d++) begin
        s = 0;
        for (int k = 0; k < WIN; k++) s += m_colsum[k][d];
        f = s / (WIN * WIN);
        if (f < bc) begin
          bc = f;
          bd = d;
        end
      end
    end
    m_x = x + 1;
    if (m_x >= w) begin
      m_x = 0;
      m_y = y + 1;
      if (m_y >= h) m_y = 0;
    end
    m_owed++;
    if (m_owed > 2 * w + 2) owe_out(bd, bc);
  endfunction

  task automatic report(string field, int unsigned exp_v, int unsigned got_v);
    $display("mismatch on %s: expected %0d, got %0d at %0t", field, exp_v, got_v, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        pix_req_t a;
        a.op = in_req.operation;
        a.lp = in_req.left_pixel;
        a.rp = in_req.right_pixel;
        predict_disparity(a);
      end
      if (!in_req.valid || in_req.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          pix_req_t n;
          n = pixel_q.pop_front();
          in_req.valid <= 1'b1;
          in_req.operation <= n.op;
          in_req.left_pixel <= n.lp;
          in_req.right_pixel <= n.rp;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_req.ready <= 1'b0;
    end else begin
      out_req.ready <= $urandom_range(99) >= recv_stall;
      if (out_req.valid && out_req.ready) begin
        if (disp_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          disp_res_t e;
          e = disp_q.pop_front();
          if (out_req.disparity !== e.disparity) report("disparity", e.disparity, out_req.disparity);
          if (out_req.best_cost !== e.best_cost) report("best_cost", e.best_cost, out_req.best_cost);
          if (out_req.frame_end !== e.frame_end) report("frame_end", e.frame_end, out_req.frame_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_req.valid && out_req.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      CFG_MAXD: m_maxd = val & 32'hF;
      CFG_WIDTH, CFG_HEIGHT: begin
        if (idx == CFG_WIDTH) m_width = val & 32'h7FF;
        else m_height = val & 32'h1FFF;
        m_x = 0;
        m_y = 0;
        m_owed = 0;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_req.valid || disp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_req(bit op, int unsigned l, int unsigned r);
    pix_req_t q;
    q.op = op;
    q.lp = l[7:0];
    q.rp = r[7:0];
    pixel_q.push_back(q);
  endtask

  // left row follows the right one shifted by a true disparity, plus noise
  task automatic push_pixels(int unsigned n, int unsigned w, bit noisy);
    bit [7:0] rh[ND];
    int unsigned dt, l, r;
    dt = $urandom_range(ND - 1);
    for (int i = 0; i < n; i++) begin
      if (i % w == 0) dt = $urandom_range(ND - 1);
      r = $urandom_range(255);
      for (int k = ND - 1; k > 0; k--) rh[k] = rh[k-1];
      rh[0] = r[7:0];
      if ((i % w) >= dt && $urandom_range(3) != 0) l = rh[dt] ^ $urandom_range(7);
      else l = $urandom_range(255);
      if (noisy && $urandom_range(15) == 0) push_req(OP_FLUSH, $urandom, $urandom);
      push_req(OP_PIXEL, l, r);
    end
  endtask

  task automatic push_flushes(int unsigned n);
    for (int i = 0; i < n; i++) push_req(OP_FLUSH, $urandom, $urandom);
  endtask

  initial begin
    int unsigned w, h, mode;
    int sent;
    m_maxd = RST_MAXD;
    m_width = RST_W;
    m_height = RST_H;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flush with nothing owed, extreme pixels on a minimal frame
    push_flushes(3);
    wait_drained();
    write_reg(CFG_MAXD, 0);
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 5);
    write_reg(CFG_UNUSED, 13'h1FFF);
    for (int i = 0; i < 25; i++) push_req(OP_PIXEL, i[0] ? 255 : 0, i[0] ? 0 : 255);
    push_flushes(14);
    wait_drained();
    write_reg(CFG_MAXD, 15);
    for (int i = 0; i < 25; i++) push_req(OP_PIXEL, 255, i % 7 == 0 ? 255 : 0);
    for (int i = 0; i < 25; i++) push_req(OP_PIXEL, 0, 0);
    push_flushes(14);
    wait_drained();

    // out-of-range geometry gets clamped
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    push_pixels(40, 5, 0);
    push_flushes(20);
    wait_drained();
    write_reg(CFG_WIDTH, 11'h7FF);
    write_reg(CFG_HEIGHT, 0);
    push_pixels(60, MAX_W, 0);
    push_flushes(64);
    wait_drained();
    write_reg(CFG_WIDTH, MAX_W);
    write_reg(CFG_HEIGHT, MAX_H);
    push_pixels(60, MAX_W, 1);
    push_flushes(70);
    wait_drained();

    sent = 0;
    mode = 0;
    while (sent < 700) begin
      case (mode % 5)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        3: begin send_idle = 31; recv_stall = 31; end
        default: begin send_idle = $urandom_range(50); recv_stall = $urandom_range(50); end
      endcase
      w = $urandom_range(12, 5);
      h = $urandom_range(8, 5);
      write_reg(CFG_MAXD, $urandom_range(15));
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      for (int f = 0; f < 2; f++) begin
        if ($urandom_range(4) == 0) begin
          push_pixels($urandom_range(w * h), w, 1);
        end else begin
          push_pixels(w * h, w, 0);
          if ($urandom_range(2) != 0) push_flushes(2 * w + 2 + $urandom_range(3));
        end
        if (f == 0 && mode % 3 == 0) wait_drained();
        sent += w * h;
      end
      push_flushes(2 * w + 4);
      wait_drained();
      mode++;
    end
    send_idle = 0;
    recv_stall = 0;
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
